@@ rtl/ptf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptf_pkg
// shared types, codes and constants of the polynomial trend feature unit
// ----------------------------------------------------------------------------
package ptf_pkg;

    localparam int MAX_DIMS_DEFAULT = 16;

    localparam int COORD_W   = 32;
    localparam int FEATURE_W = 64;
    localparam int COLUMN_W  = 8;
    localparam int POS_W     = 5;
    localparam int MODE_W    = 3;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    // 1.0 in q16.16
    localparam logic [COORD_W-1:0] ONE_Q16 = 32'h0001_0000;

    localparam logic [MODE_W-1:0] MODE_NONE        = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CONSTANT    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_LINEAR      = 3'd2;
    localparam logic [MODE_W-1:0] MODE_INTERACTIVE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_QUADRATIC   = 3'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE     = 1'b0,
        REG_NUM_DIMS = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        KIND_CONST  = 2'd0,
        KIND_LINEAR = 2'd1,
        KIND_PROD   = 2'd2,
        KIND_SQUARE = 2'd3
    } feature_kind_t;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_CONST  = 5'b00010,
        ST_LINEAR = 5'b00100,
        ST_PROD   = 5'b01000,
        ST_SQUARE = 5'b10000
    } ctrl_state_t;

    // store the accepted coordinate
    typedef struct packed {
        logic             valid;
        logic [POS_W-1:0] addr;
    } wr_cmd_t;

    // start one feature in the datapath
    typedef struct packed {
        logic                valid;
        feature_kind_t       kind;
        logic [POS_W-1:0]    addr;
        logic [COLUMN_W-1:0] column;
        logic                last_item;
        logic                last_row;
    } issue_cmd_t;

endpackage

@@ rtl/ptf_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptf_ctrl
// configuration registers, row position, column count and feature sequencer
// ----------------------------------------------------------------------------
module ptf_ctrl
    import ptf_pkg::*;
#(
    parameter int MAX_DIMS = MAX_DIMS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  advance,
    output wr_cmd_t               wr_cmd,
    output issue_cmd_t            issue_cmd
);

    localparam logic [POS_W-1:0] MAX_DIMS_P = POS_W'(MAX_DIMS);

    ctrl_state_t         state_reg, state_next;
    logic [MODE_W-1:0]   mode_cfg_reg;
    logic [POS_W-1:0]    dims_cfg_reg;
    logic [MODE_W-1:0]   mode_item_reg, mode_item_next;
    logic [POS_W-1:0]    pos_item_reg, pos_item_next;
    logic                row_end_reg, row_end_next;
    logic [POS_W-1:0]    j_reg, j_next;
    logic [COLUMN_W-1:0] col_reg, col_next;
    logic [POS_W-1:0]    position_reg, position_next;

    logic [POS_W-1:0]    dims_eff;
    logic                row_end_now;
    logic                mode_ok;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_cfg_reg <= MODE_CONSTANT;
            dims_cfg_reg <= POS_W'(1);
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_MODE:     mode_cfg_reg <= cfg_data[MODE_W-1:0];
                REG_NUM_DIMS: dims_cfg_reg <= cfg_data[POS_W-1:0];
                default:      mode_cfg_reg <= mode_cfg_reg;
            endcase
        end
    end

    // zero means one, above the store depth saturates
    always_comb
    begin
        if (dims_cfg_reg == '0)
            dims_eff = POS_W'(1);
        else if (dims_cfg_reg > MAX_DIMS_P)
            dims_eff = MAX_DIMS_P;
        else
            dims_eff = dims_cfg_reg;
    end

    assign row_end_now = ({1'b0, position_reg} + (POS_W+1)'(1)) >= {1'b0, dims_eff};
    assign mode_ok     = (mode_cfg_reg >= MODE_CONSTANT) && (mode_cfg_reg <= MODE_QUADRATIC);

    always_comb
    begin
        logic last;
        last           = 1'b0;
        state_next     = state_reg;
        mode_item_next = mode_item_reg;
        pos_item_next  = pos_item_reg;
        row_end_next   = row_end_reg;
        j_next         = j_reg;
        col_next       = col_reg;
        position_next  = position_reg;

        wr_cmd.valid = 1'b0;
        wr_cmd.addr  = position_reg;

        issue_cmd.valid     = 1'b0;
        issue_cmd.kind      = KIND_CONST;
        issue_cmd.addr      = j_reg;
        issue_cmd.column    = col_reg;
        issue_cmd.last_item = 1'b0;
        issue_cmd.last_row  = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    wr_cmd.valid   = 1'b1;
                    position_next  = row_end_now ? '0 : position_reg + POS_W'(1);
                    pos_item_next  = position_reg;
                    row_end_next   = row_end_now;
                    mode_item_next = mode_cfg_reg;
                    j_next         = '0;
                    if (position_reg == '0)
                        col_next = '0;
                    if (mode_ok)
                    begin
                        if (position_reg == '0)
                            state_next = ST_CONST;
                        else if (mode_cfg_reg >= MODE_LINEAR)
                            state_next = ST_LINEAR;
                    end
                end
            end
            ST_CONST:
            begin
                if (advance)
                begin
                    issue_cmd.valid = 1'b1;
                    issue_cmd.kind  = KIND_CONST;
                    col_next        = col_reg + COLUMN_W'(1);
                    if (mode_item_reg >= MODE_LINEAR)
                        state_next = ST_LINEAR;
                    else
                        last = 1'b1;
                end
            end
            ST_LINEAR:
            begin
                if (advance)
                begin
                    issue_cmd.valid = 1'b1;
                    issue_cmd.kind  = KIND_LINEAR;
                    col_next        = col_reg + COLUMN_W'(1);
                    if (mode_item_reg >= MODE_INTERACTIVE && pos_item_reg != '0)
                        state_next = ST_PROD;
                    else if (mode_item_reg == MODE_QUADRATIC)
                        state_next = ST_SQUARE;
                    else
                        last = 1'b1;
                end
            end
            ST_PROD:
            begin
                if (advance)
                begin
                    issue_cmd.valid = 1'b1;
                    issue_cmd.kind  = KIND_PROD;
                    col_next        = col_reg + COLUMN_W'(1);
                    if (j_reg + POS_W'(1) < pos_item_reg)
                        j_next = j_reg + POS_W'(1);
                    else if (mode_item_reg == MODE_QUADRATIC)
                        state_next = ST_SQUARE;
                    else
                        last = 1'b1;
                end
            end
            ST_SQUARE:
            begin
                if (advance)
                begin
                    issue_cmd.valid = 1'b1;
                    issue_cmd.kind  = KIND_SQUARE;
                    col_next        = col_reg + COLUMN_W'(1);
                    last            = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (last)
            state_next = ST_IDLE;
        issue_cmd.last_item = last;
        issue_cmd.last_row  = last && (row_end_reg || mode_item_reg == MODE_CONSTANT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_item_reg <= MODE_NONE;
            pos_item_reg  <= '0;
            row_end_reg   <= 1'b0;
            j_reg         <= '0;
            col_reg       <= '0;
            position_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_item_reg <= mode_item_next;
            pos_item_reg  <= pos_item_next;
            row_end_reg   <= row_end_next;
            j_reg         <= j_next;
            col_reg       <= col_next;
            position_reg  <= position_next;
        end
    end

endmodule

@@ rtl/ptf_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptf_datapath
// coordinate store, operand stage, multiplier and output register
// ----------------------------------------------------------------------------
module ptf_datapath
    import ptf_pkg::*;
#(
    parameter int MAX_DIMS = MAX_DIMS_DEFAULT
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic signed [COORD_W-1:0]   coordinate_value,
    input  wr_cmd_t                     wr_cmd,
    input  issue_cmd_t                  issue_cmd,
    output logic                        advance,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [FEATURE_W-1:0] feature_value,
    output logic [COLUMN_W-1:0]         feature_column,
    output logic                        last_of_item,
    output logic                        last_of_row
);

    localparam int IDX_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

    logic [COORD_W-1:0] coord_mem [MAX_DIMS];
    logic [COORD_W-1:0] x_reg;

    // operand stage
    logic                s1_valid_reg;
    logic [COORD_W-1:0]  s1_a_reg;
    logic [COORD_W-1:0]  s1_b_reg;
    logic                s1_use_mem_reg;
    logic [COORD_W-1:0]  rd_data_reg;
    logic [COLUMN_W-1:0] s1_col_reg;
    logic                s1_last_item_reg;
    logic                s1_last_row_reg;

    // output stage
    logic                        out_valid_reg;
    logic signed [FEATURE_W-1:0] out_value_reg;
    logic [COLUMN_W-1:0]         out_col_reg;
    logic                        out_last_item_reg;
    logic                        out_last_row_reg;

    logic [COORD_W-1:0]          a_next, b_next;
    logic signed [COORD_W-1:0]   mul_a, mul_b;
    logic signed [FEATURE_W-1:0] product;

    // whole pipe moves together when the output slot frees up
    assign advance = !out_valid_reg || out_ready;

    always_comb
    begin
        case (issue_cmd.kind)
            KIND_CONST:
            begin
                a_next = ONE_Q16;
                b_next = ONE_Q16;
            end
            KIND_LINEAR:
            begin
                a_next = x_reg;
                b_next = ONE_Q16;
            end
            KIND_PROD:
            begin
                a_next = x_reg;
                b_next = ONE_Q16;
            end
            KIND_SQUARE:
            begin
                a_next = x_reg;
                b_next = x_reg;
            end
            default:
            begin
                a_next = x_reg;
                b_next = x_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_cmd.valid)
        begin
            coord_mem[wr_cmd.addr[IDX_W-1:0]] <= coordinate_value;
            x_reg                             <= coordinate_value;
        end
        if (advance && issue_cmd.valid)
        begin
            rd_data_reg      <= coord_mem[issue_cmd.addr[IDX_W-1:0]];
            s1_a_reg         <= a_next;
            s1_b_reg         <= b_next;
            s1_use_mem_reg   <= (issue_cmd.kind == KIND_PROD);
            s1_col_reg       <= issue_cmd.column;
            s1_last_item_reg <= issue_cmd.last_item;
            s1_last_row_reg  <= issue_cmd.last_row;
        end
    end

    // signed 32x32, operands sign-extended to the full product width
    assign mul_a   = s1_a_reg;
    assign mul_b   = s1_use_mem_reg ? rd_data_reg : s1_b_reg;
    assign product = FEATURE_W'(mul_a) * FEATURE_W'(mul_b);

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            out_value_reg     <= product;
            out_col_reg       <= s1_col_reg;
            out_last_item_reg <= s1_last_item_reg;
            out_last_row_reg  <= s1_last_row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= issue_cmd.valid;
            out_valid_reg <= s1_valid_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign feature_value  = out_value_reg;
    assign feature_column = out_col_reg;
    assign last_of_item   = out_last_item_reg;
    assign last_of_row    = out_last_row_reg;

endmodule

@@ rtl/polynomial_trend_features_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polynomial_trend_features_unit
// streams q16.16 sample coordinates in and polynomial feature columns, up to quadratic, out
// ----------------------------------------------------------------------------
//
// channel   direction  handshake              payload
// cfg       in         cfg_valid / cfg_ready  cfg_index, cfg_data
// in        in         in_valid / in_ready    coordinate_value
// out       out        out_valid / out_ready  feature_value, feature_column,
//                                             last_of_item, last_of_row
//
// a coordinate word is accepted, then the sequencer issues one feature per
// cycle while the output is not stalled, set by the single shared 32x32
// multiplier; one word yields up to MAX_DIMS+1 results, which pass the
// operand/store read stage, then the multiply into the output register
// a word that causes no result is done in its accept cycle
// reset (async, active low) clears control and sets mode constant, one dim;
// the coordinate store needs no clearing pass, only entries of the current
// row are read
// a stalled output freezes the operand and output stages and the sequencer;
// the next coordinate is taken once the previous one has issued its last
// feature, while those features may still be draining
//
module polynomial_trend_features_unit
    import ptf_pkg::*;
#(
    parameter int MAX_DIMS = MAX_DIMS_DEFAULT
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration writes
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,
    // coordinate words
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic signed [COORD_W-1:0]   coordinate_value,
    // feature words
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [FEATURE_W-1:0] feature_value,
    output logic [COLUMN_W-1:0]         feature_column,
    output logic                        last_of_item,
    output logic                        last_of_row
);

    wr_cmd_t    wr_cmd;
    issue_cmd_t issue_cmd;
    logic       advance;

    // sequencer: config, row position, column count, feature order
    ptf_ctrl #(
        .MAX_DIMS (MAX_DIMS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .advance   (advance),
        .wr_cmd    (wr_cmd),
        .issue_cmd (issue_cmd)
    );

    // store, operand select, multiplier, output register
    ptf_datapath #(
        .MAX_DIMS (MAX_DIMS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .coordinate_value (coordinate_value),
        .wr_cmd           (wr_cmd),
        .issue_cmd        (issue_cmd),
        .advance          (advance),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .feature_value    (feature_value),
        .feature_column   (feature_column),
        .last_of_item     (last_of_item),
        .last_of_row      (last_of_row)
    );

endmodule
